/* hw/rtl/mke_pkg.sv */
// Package for the Morse keying encoder: payload types, command and status
// structs between controller and datapath, and the character code table.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package mke_pkg;

  // Character codes that the table recognizes.
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Units left after the first one of a dash, and of the trailing gap.
  localparam logic [1:0] DASH_REST = 2'd2;
  localparam logic [1:0] GAP_REST  = 2'd2;

  // Controller state codes.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MARK   = 3'd1;
  localparam logic [2:0] S_SPACE  = 3'd2;
  localparam logic [2:0] S_SINGLE = 3'd3;
  localparam logic [2:0] S_GAP    = 3'd4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       message_end;
  } in_t;

  typedef struct packed {
    logic key_level;
    logic run_last;
    logic unknown_char;
  } out_t;

  // One table entry: element count and dash pattern, first element at the MSB.
  typedef struct packed {
    logic [2:0] len;
    logic [3:0] pat;
  } code_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit;
    logic level;
    logic last;
    logic unit_dec;
    logic elem_next;
    logic gap_load;
    logic gap_dec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic in_single;
    logic units_zero;
    logic elem_last;
    logic gap_zero;
    logic unknown;
    logic msg_end;
  } status_t;

  // Letter table, A through Z; a set pattern bit is a dash.
  function automatic code_t lookup(input logic [4:0] idx);
    code_t c;
    begin
      case (idx)
        5'd0:    c = '{len: 3'd2, pat: 4'b0100};
        5'd1:    c = '{len: 3'd4, pat: 4'b1000};
        5'd2:    c = '{len: 3'd4, pat: 4'b1010};
        5'd3:    c = '{len: 3'd3, pat: 4'b1000};
        5'd4:    c = '{len: 3'd1, pat: 4'b0000};
        5'd5:    c = '{len: 3'd4, pat: 4'b0010};
        5'd6:    c = '{len: 3'd3, pat: 4'b1100};
        5'd7:    c = '{len: 3'd4, pat: 4'b0000};
        5'd8:    c = '{len: 3'd2, pat: 4'b0000};
        5'd9:    c = '{len: 3'd4, pat: 4'b0111};
        5'd10:   c = '{len: 3'd3, pat: 4'b1010};
        5'd11:   c = '{len: 3'd4, pat: 4'b0100};
        5'd12:   c = '{len: 3'd2, pat: 4'b1100};
        5'd13:   c = '{len: 3'd2, pat: 4'b1000};
        5'd14:   c = '{len: 3'd3, pat: 4'b1110};
        5'd15:   c = '{len: 3'd4, pat: 4'b0110};
        5'd16:   c = '{len: 3'd4, pat: 4'b1101};
        5'd17:   c = '{len: 3'd3, pat: 4'b0100};
        5'd18:   c = '{len: 3'd3, pat: 4'b0000};
        5'd19:   c = '{len: 3'd1, pat: 4'b1000};
        5'd20:   c = '{len: 3'd3, pat: 4'b0010};
        5'd21:   c = '{len: 3'd4, pat: 4'b0001};
        5'd22:   c = '{len: 3'd3, pat: 4'b0110};
        5'd23:   c = '{len: 3'd4, pat: 4'b1001};
        5'd24:   c = '{len: 3'd4, pat: 4'b1011};
        5'd25:   c = '{len: 3'd4, pat: 4'b1100};
        default: c = '{len: 3'd1, pat: 4'b0000};
      endcase
      return c;
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mke_datapath.sv */
// Datapath of the Morse keying encoder: code table lookup, element and unit
// counters, and the output register. Uses mke_pkg; driven by mke_ctrl.
`default_nettype none

module mke_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mke_pkg::in_t    in_data,
  input  wire mke_pkg::cmd_t   cmd,
  output mke_pkg::status_t     status,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output mke_pkg::out_t        out_data
);

  logic           is_letter;
  logic           is_space;
  logic [4:0]     idx;
  mke_pkg::code_t entry;

  // Dash bits of the elements still to come, next one at the MSB.
  logic [2:0] code;
  logic [2:0] elems;
  logic [1:0] units;
  logic [1:0] gap;
  logic       msg_end;
  logic       unknown;

  // Classify the incoming character and look it up.
  always_comb begin
    is_letter = (in_data.char_code >= mke_pkg::CHAR_A) &&
                (in_data.char_code <= mke_pkg::CHAR_Z);
    is_space  = (in_data.char_code == mke_pkg::CHAR_SPACE);
    idx       = 5'(in_data.char_code - mke_pkg::CHAR_A);
    entry     = mke_pkg::lookup(idx);
  end

  // Character registers and counters.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code    <= entry.pat[2:0];
      elems   <= entry.len;
      units   <= entry.pat[3] ? mke_pkg::DASH_REST : 2'd0;
      msg_end <= in_data.message_end;
      unknown <= !is_letter && !is_space;
    end else if (cmd.elem_next) begin
      code  <= {code[1:0], 1'b0};
      elems <= elems - 3'd1;
      units <= code[2] ? mke_pkg::DASH_REST : 2'd0;
    end else if (cmd.unit_dec) begin
      units <= units - 2'd1;
    end
    if (cmd.gap_load) begin
      gap <= mke_pkg::GAP_REST;
    end else if (cmd.gap_dec) begin
      gap <= gap - 2'd1;
    end
  end

  // Output register: a new unit enters when the slot is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.key_level    <= cmd.level;
      out_data.run_last     <= cmd.last;
      out_data.unknown_char <= unknown;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.slot_free  = !out_valid || out_ready;
    status.in_single  = !is_letter;
    status.units_zero = (units == 2'd0);
    status.elem_last  = (elems == 3'd1);
    status.gap_zero   = (gap == 2'd0);
    status.unknown    = unknown;
    status.msg_end    = msg_end;
  end

endmodule

`default_nettype wire

/* hw/rtl/mke_ctrl.sv */
// Controller of the Morse keying encoder: sequences marks, element spaces,
// single off units and the trailing gap. Uses mke_pkg; drives mke_datapath.
`default_nettype none

module mke_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mke_pkg::status_t  status,
  output mke_pkg::cmd_t          cmd
);

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mke_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == mke_pkg::S_IDLE);

  // Next state and commands; a unit is only produced when the output slot frees.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      mke_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_single ? mke_pkg::S_SINGLE : mke_pkg::S_MARK;
        end
      end
      mke_pkg::S_MARK: begin
        if (status.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.level = 1'b1;
          if (!status.units_zero) begin
            cmd.unit_dec = 1'b1;
          end else if (!status.elem_last) begin
            cmd.elem_next = 1'b1;
            state_next    = mke_pkg::S_SPACE;
          end else if (status.msg_end) begin
            cmd.last   = 1'b1;
            state_next = mke_pkg::S_IDLE;
          end else begin
            cmd.gap_load = 1'b1;
            state_next   = mke_pkg::S_GAP;
          end
        end
      end
      mke_pkg::S_SPACE: begin
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = mke_pkg::S_MARK;
        end
      end
      mke_pkg::S_SINGLE: begin
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          if (status.unknown || status.msg_end) begin
            cmd.last   = 1'b1;
            state_next = mke_pkg::S_IDLE;
          end else begin
            cmd.gap_load = 1'b1;
            state_next   = mke_pkg::S_GAP;
          end
        end
      end
      mke_pkg::S_GAP: begin
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          if (status.gap_zero) begin
            cmd.last   = 1'b1;
            state_next = mke_pkg::S_IDLE;
          end else begin
            cmd.gap_dec = 1'b1;
          end
        end
      end
      default: begin
        state_next = mke_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/morse_keying_encoder.sv */
// A character is taken while the controller is idle; the controller then
// emits one time unit per cycle into the output register while out_ready
// stays high, and takes no new character until it has emitted the last unit
// of the current one.
// Reset (rst, synchronous): controller returns to idle and the output is empty.
// Top level of the Morse keying encoder; uses mke_pkg, mke_ctrl, mke_datapath.
`default_nettype none

module morse_keying_encoder (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mke_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mke_pkg::out_t      out_data
);

  mke_pkg::cmd_t    cmd;
  mke_pkg::status_t status;

  mke_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mke_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* hw/rtl/mke_checker.sv */
// Port-level checks for the Morse keying encoder, bound to the top level.
// Uses mke_pkg for the payload types.
`default_nettype none

module mke_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire mke_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire mke_pkg::out_t out_data
);

  // A waiting input transfer keeps its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // After an input transfer the block is not ready in the cycle after it.
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // An unknown character gives a single off unit that ends its run.
  a_unknown_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.unknown_char |-> out_data.run_last && !out_data.key_level)
    else $error("unknown character unit malformed");

  // Reset leaves the block idle with an empty output.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind morse_keying_encoder mke_checker u_mke_checker (.*);

`default_nettype wire
